>>> rtl/rbws_pkg.sv
`default_nettype none

package rbws_pkg;

  localparam int WORD_BITS   = 64;
  localparam int OFFSET_BITS = 16;
  localparam int RING_BYTES  = 65536;

  localparam int WORD_BYTES = WORD_BITS / 8;
  localparam int SHIFT_W    = $clog2(WORD_BYTES);

  // Wide enough for offset + length and for the ring size itself
  localparam int SUM_W  = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;
  localparam int RING_W = $clog2(RING_BYTES) + 1;
  localparam int LEN_W  = (SUM_W > RING_W) ? SUM_W : RING_W;

  localparam logic [63:0] DATA_MASK = 64'((65'd1 << WORD_BITS) - 65'd1);
  localparam logic [7:0]  KEEP_MASK = 8'((9'd1 << WORD_BYTES) - 9'd1);
  localparam logic [31:0] OFF_MASK  = 32'((33'd1 << OFFSET_BITS) - 33'd1);

  // tdata: addr, length, data, keep from the lowest bit up
  localparam int TDATA_W = 120;
  localparam int OUSER_W = 2;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CUT_FIRST,
    MODE_ALIGN_SECOND,
    MODE_FWD_ALIGNED
  } mode_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [15:0] length;
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
    logic        run_end;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/ring_buffer_write_splitter_unit.sv
`default_nettype none

// Splits a write command that wraps past the end of the ring buffer into two
// commands and realigns the packet words that follow the wrap point. Each
// input transfer is either a command (tuser = 0) or a packet word (tuser = 1)
// and causes zero to three result transfers, delivered in the order data word,
// command, residue word; tuser[1] marks the last result of one input. An
// input goes through an input register and a result register. Items that
// cause one result each stream at one per cycle while the output accepts; an
// item with several results holds the result register until all are taken,
// and the input side waits meanwhile.
module ring_buffer_write_splitter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // cmd_addr[31:0], cmd_length[47:32], in_data[111:48], in_keep[119:112]
  input  wire logic [rbws_pkg::TDATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic                          s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_addr[31:0], out_length[47:32], out_data[111:48], out_keep[119:112]
  output logic [rbws_pkg::TDATA_W-1:0]       m_axis_tdata,
  // kind[0], run_end[1]
  output logic [rbws_pkg::OUSER_W-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);
  import rbws_pkg::*;

  function automatic res_t mk_cmd(input logic [31:0] a, input logic [15:0] l);
    res_t r;
    r        = '0;
    r.kind   = KIND_CMD;
    r.addr   = a;
    r.length = l;
    return r;
  endfunction

  function automatic res_t mk_word(input logic [63:0] d, input logic [7:0] k,
                                   input logic lst);
    res_t r;
    r      = '0;
    r.kind = KIND_WORD;
    r.data = d;
    r.keep = k;
    r.last = lst;
    return r;
  endfunction

  // Low bytes from the prior word above the shift, high bytes from the next word
  function automatic res_t realign(input logic [63:0] pd, input logic [7:0] pk,
                                   input logic [SHIFT_W-1:0] s,
                                   input logic [63:0] nd, input logic [7:0] nk,
                                   input logic lst);
    logic [63:0] d;
    logic [7:0]  k;
    int unsigned sh;
    sh = int'(s);
    d  = ((pd >> (8 * sh)) | (nd << (WORD_BITS - 8 * sh))) & DATA_MASK;
    k  = ((pk >> sh) | (nk << (WORD_BYTES - sh))) & KEEP_MASK;
    return mk_word(d, k, lst);
  endfunction

  // Input register
  logic        in_valid;
  logic        in_op;
  logic [31:0] in_addr;
  logic [15:0] in_len;
  logic [63:0] in_data;
  logic [7:0]  in_keep;
  logic        in_last;

  // Result register: up to three results, slot 0 is presented
  res_t        slot [3];
  logic [1:0]  cnt;

  // Split state
  mode_t              mode, mode_next;
  logic [31:0]        held_addr, held_addr_next;
  logic [15:0]        held_length, held_length_next;
  logic [LEN_W-1:0]   first_part_length, first_part_length_next;
  logic [LEN_W-1:0]   bytes_left_first, bytes_left_first_next;
  logic [SHIFT_W-1:0] byte_shift, byte_shift_next;
  logic [63:0]        prior_data, prior_data_next;
  logic [7:0]         prior_keep, prior_keep_next;

  res_t       slot_next [3];
  logic [1:0] cnt_next;

  logic take, load;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign load          = in_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && take));
  assign s_axis_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_addr <= s_axis_tdata[31:0];
      in_len  <= s_axis_tdata[47:32];
      in_data <= s_axis_tdata[111:48] & DATA_MASK;
      in_keep <= s_axis_tdata[119:112] & KEEP_MASK;
      in_last <= s_axis_tlast;
    end
  end

  always_comb begin
    logic [OFFSET_BITS-1:0] off;
    logic [LEN_W-1:0]       off_w;
    logic [LEN_W-1:0]       first_w;
    logic [15:0]            rest;
    logic [31:0]            second_addr;
    logic [7:0]             part_keep;
    logic                   seg_end;

    mode_next              = mode;
    held_addr_next         = held_addr;
    held_length_next       = held_length;
    first_part_length_next = first_part_length;
    bytes_left_first_next  = bytes_left_first;
    byte_shift_next        = byte_shift;
    prior_data_next        = prior_data;
    prior_keep_next        = prior_keep;
    slot_next[0]           = '0;
    slot_next[1]           = '0;
    slot_next[2]           = '0;
    cnt_next               = 2'd0;

    off         = in_addr[OFFSET_BITS-1:0];
    off_w       = LEN_W'(off);
    first_w     = LEN_W'(RING_BYTES) - off_w;
    rest        = held_length - first_part_length[15:0];
    second_addr = held_addr & ~OFF_MASK;
    part_keep   = ~(8'hFF << bytes_left_first[SHIFT_W-1:0]) & KEEP_MASK;
    seg_end     = !in_keep[byte_shift];

    if (in_op == OP_CMD) begin
      if (mode == MODE_IDLE) begin
        held_addr_next   = in_addr;
        held_length_next = in_len;
        cnt_next         = 2'd1;
        if ((off_w < LEN_W'(RING_BYTES)) &&
            ((off_w + LEN_W'(in_len)) > LEN_W'(RING_BYTES))) begin
          first_part_length_next = first_w;
          bytes_left_first_next  = first_w;
          byte_shift_next        = first_w[SHIFT_W-1:0];
          slot_next[0]           = mk_cmd(in_addr, first_w[15:0]);
          mode_next              = MODE_CUT_FIRST;
        end else begin
          slot_next[0] = mk_cmd(in_addr, in_len);
          mode_next    = MODE_FWD_ALIGNED;
        end
      end
    end else begin
      case (mode)
        MODE_CUT_FIRST: begin
          prior_data_next = in_data;
          prior_keep_next = in_keep;
          if (bytes_left_first > LEN_W'(WORD_BYTES)) begin
            bytes_left_first_next = bytes_left_first - LEN_W'(WORD_BYTES);
            slot_next[0]          = mk_word(in_data, in_keep, in_last);
            cnt_next              = 2'd1;
          end else if (bytes_left_first == LEN_W'(WORD_BYTES)) begin
            slot_next[0] = mk_word(in_data, in_keep, 1'b1);
            slot_next[1] = mk_cmd(second_addr, rest);
            cnt_next     = 2'd2;
            mode_next    = MODE_FWD_ALIGNED;
          end else begin
            slot_next[0] = mk_word(in_data, part_keep, 1'b1);
            slot_next[1] = mk_cmd(second_addr, rest);
            cnt_next     = 2'd2;
            mode_next    = MODE_ALIGN_SECOND;
            if (in_last) begin
              // Residue from the word just taken, shift = its partial length
              slot_next[2] = realign(in_data, in_keep, byte_shift, '0, '0, 1'b1);
              cnt_next     = 2'd3;
              mode_next    = MODE_IDLE;
            end
          end
        end
        MODE_FWD_ALIGNED: begin
          slot_next[0] = mk_word(in_data, in_keep, in_last);
          cnt_next     = 2'd1;
          if (in_last) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_ALIGN_SECOND: begin
          slot_next[0]    = realign(prior_data, prior_keep, byte_shift,
                                    in_data, in_keep, seg_end);
          cnt_next        = 2'd1;
          prior_data_next = in_data;
          prior_keep_next = in_keep;
          if (in_last) begin
            mode_next = MODE_IDLE;
            if (!seg_end) begin
              slot_next[1] = realign(in_data, in_keep, byte_shift, '0, '0, 1'b1);
              cnt_next     = 2'd2;
            end
          end
        end
        default: begin
          // idle: drop stray data words
          cnt_next = 2'd0;
        end
      endcase
    end

    case (cnt_next)
      2'd1:    slot_next[0].run_end = 1'b1;
      2'd2:    slot_next[1].run_end = 1'b1;
      2'd3:    slot_next[2].run_end = 1'b1;
      default: slot_next[0].run_end = slot_next[0].run_end;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      held_addr         <= '0;
      held_length       <= '0;
      first_part_length <= '0;
      bytes_left_first  <= '0;
      byte_shift        <= '0;
      prior_data        <= '0;
      prior_keep        <= '0;
    end else if (load) begin
      mode              <= mode_next;
      held_addr         <= held_addr_next;
      held_length       <= held_length_next;
      first_part_length <= first_part_length_next;
      bytes_left_first  <= bytes_left_first_next;
      byte_shift        <= byte_shift_next;
      prior_data        <= prior_data_next;
      prior_keep        <= prior_keep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= cnt_next;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Advance the queued results toward slot 0 on each output transfer
  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= slot_next[0];
      slot[1] <= slot_next[1];
      slot[2] <= slot_next[2];
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = {slot[0].keep, slot[0].data, slot[0].length, slot[0].addr};
  assign m_axis_tuser  = {slot[0].run_end, slot[0].kind};
  assign m_axis_tlast  = slot[0].last;

  a_run_end_on_final: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (cnt == 2'd1)) |-> slot[0].run_end)
    else $error("final queued result lacks run_end");

  a_no_early_run_end: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> !slot[0].run_end)
    else $error("run_end on a result that is not the last of its item");

  a_shift_in_realign: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ALIGN_SECOND) |-> (byte_shift != '0))
    else $error("realign mode with zero byte shift");

  a_cut_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CUT_FIRST) |->
      ((bytes_left_first != '0) && (bytes_left_first <= first_part_length)))
    else $error("first part byte count out of range");

  a_load_drains: assert property (@(posedge clk) disable iff (rst)
    (load && !$past(rst)) |=> (cnt <= 2'd3))
    else $error("result count overflow");

endmodule

`default_nettype wire

>>> sim/tb_ring_buffer_write_splitter_unit.sv
`timescale 1ns / 1ps

module tb_ring_buffer_write_splitter_unit;
  import rbws_pkg::*;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // cmd_addr[31:0], cmd_length[47:32], in_data[111:48], in_keep[119:112]
  logic [TDATA_W-1:0] s_axis_tdata;
  // op
  logic               s_axis_tuser;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // out_addr[31:0], out_length[47:32], out_data[111:48], out_keep[119:112]
  logic [TDATA_W-1:0] m_axis_tdata;
  // kind[0], run_end[1]
  logic [OUSER_W-1:0] m_axis_tuser;
  logic               m_axis_tlast;

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int acted_items;

  res_t pending_writes[$];

  // Mirror of the splitter state
  mode_t              mode;
  logic [31:0]        held_addr;
  logic [15:0]        held_length;
  logic [16:0]        first_len;
  logic [16:0]        left_first;
  logic [SHIFT_W-1:0] byte_shift;
  logic [63:0]        prior_data;
  logic [7:0]         prior_keep;

  ring_buffer_write_splitter_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic res_t cmd_result(input logic [31:0] a, input logic [15:0] l);
    res_t r;
    r = '0;
    r.kind = KIND_CMD;
    r.addr = a;
    r.length = l;
    return r;
  endfunction

  function automatic res_t word_result(input logic [63:0] d, input logic [7:0] k,
                                       input logic l);
    res_t r;
    r = '0;
    r.kind = KIND_WORD;
    r.data = d;
    r.keep = k;
    r.last = l;
    return r;
  endfunction

  // Low bytes from the held word above the shift, high bytes from the next word
  function automatic void realign_word(input logic [63:0] nd, input logic [7:0] nk,
                                       output logic [63:0] d, output logic [7:0] k);
    d = ((prior_data >> (8 * byte_shift)) | (nd << (8 * (WORD_BYTES - byte_shift))))
        & DATA_MASK;
    k = ((prior_keep >> byte_shift) | (nk << (WORD_BYTES - byte_shift))) & KEEP_MASK;
  endfunction

  function automatic int split_and_realign(input logic op, input logic [31:0] addr,
                                           input logic [15:0] len,
                                           input logic [63:0] data_in,
                                           input logic [7:0] keep_in, input logic lst);
    res_t        step_res [3];
    int          n;
    logic [31:0] off;
    logic [63:0] data;
    logic [63:0] d;
    logic [7:0]  keep;
    logic [7:0]  k;
    logic [15:0] rest;
    logic        seg_end;
    n = 0;
    data = data_in & DATA_MASK;
    keep = keep_in & KEEP_MASK;
    if (op == OP_CMD) begin
      if (mode == MODE_IDLE) begin
        off = addr & OFF_MASK;
        held_addr = addr;
        held_length = len;
        if (off < RING_BYTES && off + len > RING_BYTES) begin
          first_len = 17'(RING_BYTES - off);
          left_first = first_len;
          byte_shift = SHIFT_W'(first_len % WORD_BYTES);
          step_res[n] = cmd_result(addr, 16'(first_len));
          n++;
          mode = MODE_CUT_FIRST;
        end else begin
          step_res[n] = cmd_result(addr, len);
          n++;
          mode = MODE_FWD_ALIGNED;
        end
      end
    end else begin
      case (mode)
        MODE_CUT_FIRST: begin
          prior_data = data;
          prior_keep = keep;
          if (left_first > WORD_BYTES) begin
            left_first -= 17'(WORD_BYTES);
            step_res[n] = word_result(data, keep, lst);
            n++;
          end else begin
            rest = 16'(held_length - first_len);
            if (left_first == WORD_BYTES) begin
              step_res[n] = word_result(data, keep, 1'b1);
              step_res[n+1] = cmd_result(held_addr & ~OFF_MASK, rest);
              n += 2;
              mode = MODE_FWD_ALIGNED;
            end else begin
              // trim keep to the bytes left in the first part
              step_res[n] = word_result(data, 8'((9'd1 << left_first) - 9'd1) & KEEP_MASK,
                                        1'b1);
              step_res[n+1] = cmd_result(held_addr & ~OFF_MASK, rest);
              n += 2;
              mode = MODE_ALIGN_SECOND;
              if (lst) begin
                realign_word('0, '0, d, k);
                step_res[n] = word_result(d, k, 1'b1);
                n++;
                mode = MODE_IDLE;
              end
            end
          end
        end
        MODE_FWD_ALIGNED: begin
          step_res[n] = word_result(data, keep, lst);
          n++;
          if (lst) mode = MODE_IDLE;
        end
        MODE_ALIGN_SECOND: begin
          seg_end = ~keep[byte_shift];
          realign_word(data, keep, d, k);
          step_res[n] = word_result(d, k, seg_end);
          n++;
          prior_data = data;
          prior_keep = keep;
          if (lst) begin
            mode = MODE_IDLE;
            if (!seg_end) begin
              realign_word('0, '0, d, k);
              step_res[n] = word_result(d, k, 1'b1);
              n++;
            end
          end
        end
        default: ;
      endcase
    end
    if (n > 0) step_res[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) pending_writes.push_back(step_res[i]);
    return n;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t", what, $realtime);
      $display("  expected kind=%0d addr=%h len=%h data=%h keep=%h last=%0d end=%0d",
               want.kind, want.addr, want.length, want.data, want.keep, want.last,
               want.run_end);
      $display("  actual   kind=%0d addr=%h len=%h data=%h keep=%h last=%0d end=%0d",
               got.kind, got.addr, got.length, got.data, got.keep, got.last, got.run_end);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser[0];
      got.run_end = m_axis_tuser[1];
      got.addr    = m_axis_tdata[31:0];
      got.length  = m_axis_tdata[47:32];
      got.data    = m_axis_tdata[111:48];
      got.keep    = m_axis_tdata[119:112];
      got.last    = m_axis_tlast;
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) report_mismatch("transfer mismatch", want, got);
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Drive one input transfer; returns at the falling edge after it is taken
  task automatic send_item(input logic op, input logic [31:0] addr, input logic [15:0] len,
                           input logic [63:0] data, input logic [7:0] keep,
                           input logic lst);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {keep, data, len, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (split_and_realign(op, addr, len, data, keep, lst) > 0) acted_items++;
    @(negedge clk);
  endtask

  // Close out whatever packet is open with last-marked words
  task automatic finish_packet();
    while (mode != MODE_IDLE)
      send_item(OP_DATA, $urandom, 16'($urandom), rand_word(), 8'($urandom), 1'b1);
  endtask

  task automatic test_ignored_items();
    send_item(OP_DATA, '1, '1, '1, 8'hFF, 1'b1);
  endtask

  task automatic test_unsplit_pass_through();
    send_item(OP_CMD, 32'h0000_0000, 16'h0000, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, '0, 8'h00, 1'b1);
    send_item(OP_CMD, 32'h1234_0000, 16'hFFFF, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, '1, 8'hFF, 1'b1);
    // offset plus length lands exactly on the ring end: no split
    send_item(OP_CMD, 32'hABCD_0001, 16'hFFFF, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, 64'h0123_4567_89AB_CDEF, 8'h0F, 1'b1);
  endtask

  task automatic test_partial_split();
    send_item(OP_CMD, 32'hFFFF_FFFF, 16'hFFFF, '0, 8'h00, 1'b0);
    send_item(OP_CMD, 32'h0000_1000, 16'h0010, '1, 8'hFF, 1'b1);
    send_item(OP_DATA, '0, '0, '1, 8'hFF, 1'b0);
    send_item(OP_DATA, '0, '0, 64'hA5A5_5A5A_F0F0_0F0F, 8'h01, 1'b0);
    send_item(OP_DATA, '0, '0, 64'h1122_3344_5566_7788, 8'hFF, 1'b1);
    // partial word that also ends the packet: word, command and residue at once
    send_item(OP_CMD, 32'h0000_FFFD, 16'd10, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, 64'hDEAD_BEEF_CAFE_F00D, 8'hFF, 1'b1);
  endtask

  task automatic test_aligned_split();
    send_item(OP_CMD, 32'h5555_FFF0, 16'd32, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'h3F, 1'b1);
  endtask

  task automatic test_short_packet();
    send_item(OP_CMD, 32'h0F0F_FFE8, 16'd40, '0, 8'h00, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b1);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b1);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b0);
    send_item(OP_DATA, '0, '0, rand_word(), 8'hFF, 1'b1);
  endtask

  task automatic test_random_traffic(input int target);
    int          start;
    int          nwords;
    logic [31:0] addr;
    logic [31:0] off;
    logic [15:0] len;
    logic [7:0]  keep;
    logic        brk;
    start = acted_items;
    while (acted_items - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), $urandom, 16'($urandom), rand_word(),
                  8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          // place the offset close to the ring end so most commands wrap
          addr = ($urandom & ~OFF_MASK) | ((RING_BYTES - $urandom_range(1, 160)) & OFF_MASK);
          len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        end else begin
          addr = $urandom;
          len = 16'($urandom_range(0, 400));
        end
        off = addr & OFF_MASK;
        if (off + len > RING_BYTES)
          nwords = (RING_BYTES - off + WORD_BYTES - 1) / WORD_BYTES + $urandom_range(0, 4);
        else
          nwords = $urandom_range(1, 6);
        send_item(OP_CMD, addr, len, rand_word(), 8'($urandom), 1'($urandom_range(0, 1)));
        for (int i = 0; i < nwords; i++) begin
          if ($urandom_range(0, 24) == 0)
            send_item(OP_CMD, $urandom, 16'($urandom), rand_word(), 8'($urandom), 1'b0);
          keep = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF;
          brk = ($urandom_range(0, 19) == 0);
          send_item(OP_DATA, $urandom, 16'($urandom), rand_word(), keep,
                    (i == nwords - 1) || brk);
          if (brk) break;
        end
      end
      finish_packet();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    acted_items   = 0;
    mode          = MODE_IDLE;
    held_addr     = '0;
    held_length   = '0;
    first_len     = '0;
    left_first    = '0;
    byte_shift    = '0;
    prior_data    = '0;
    prior_keep    = '0;
    src_idle_pct  = 30;
    sink_idle_pct = 81;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_ignored_items();
    test_unsplit_pass_through();
    test_partial_split();
    test_aligned_split();
    test_short_packet();
    test_random_traffic(95);

    src_idle_pct  = 81;
    sink_idle_pct = 30;
    test_random_traffic(100);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(100);

    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
